FILE: rtl/psc_pkg.sv
// types and constants shared by the pressure sensor compensation block
`default_nettype none

package psc_pkg;

  localparam int RawW = 24;
  localparam int CalW = 16;
  localparam int OutW = 32;
  localparam int CfgAddrW = 5;
  localparam int CfgDataW = 32;

  localparam int DtW = 25;
  localparam int PrW = 42;
  localparam int DsqW = 49;
  localparam int TdW = 18;
  localparam int TvW = 19;
  localparam int T2W = 17;
  localparam int SqW = 34;
  localparam int Off1W = 36;
  localparam int Sens1W = 35;
  localparam int Off2W = 38;
  localparam int Sens2W = 37;
  localparam int OffW = 40;
  localparam int SensW = 39;

  localparam int SplitW = 20;
  localparam int SensHiW = SensW - SplitW;
  localparam int PpW = SplitW + RawW;
  localparam int ProdW = 63;
  localparam int ProdShift = 21;
  localparam int QW = ProdW - ProdShift;
  localparam int XW = QW + 1;
  localparam int PresShift = 15;
  localparam int PW = XW - PresShift;

  localparam int TempRef = 2000;
  localparam int TempCold = -1500;
  localparam int ColdOffset = TempRef - TempCold;

  typedef enum logic [2:0] {
    REG_PRESSURE_SENSITIVITY = 3'd0,
    REG_PRESSURE_OFFSET      = 3'd1,
    REG_SENS_TEMP_COEFF      = 3'd2,
    REG_OFFSET_TEMP_COEFF    = 3'd3,
    REG_REFERENCE_TEMP       = 3'd4,
    REG_TEMP_SENSITIVITY     = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [CalW-1:0] pressure_sensitivity;
    logic [CalW-1:0] pressure_offset;
    logic [CalW-1:0] sens_temp_coeff;
    logic [CalW-1:0] offset_temp_coeff;
    logic [CalW-1:0] reference_temp;
    logic [CalW-1:0] temp_sensitivity;
  } cal_t;

  typedef struct packed {
    logic [RawW-1:0] raw_temperature;
    logic [RawW-1:0] raw_pressure;
  } in_item_t;

  typedef struct packed {
    logic signed [OutW-1:0] temperature_centi;
    logic signed [OutW-1:0] pressure_tenth_mbar;
  } out_item_t;

  typedef struct packed {
    logic signed [TdW-1:0]    td;
    logic signed [TvW-1:0]    tv;
    logic [T2W-1:0]           t2;
    logic signed [Off1W-1:0]  off1;
    logic signed [Sens1W-1:0] sens1;
    logic [RawW-1:0]          d1;
  } fo_item_t;

  typedef struct packed {
    logic signed [OutW-1:0]  tout;
    logic signed [OffW-1:0]  off;
    logic signed [SensW-1:0] sens;
    logic [RawW-1:0]         d1;
  } so_item_t;

endpackage

`default_nettype wire

FILE: rtl/pressure_sensor_compensation.sv
// Second-order compensation of raw pressure and temperature readings against six
// calibration words. Fully pipelined: one item per cycle unless the output stalls,
// through 3 stages of first-order terms, 3 of band corrections and 5 for the pressure
// product and its two truncating scalings. Valid bits travel with each stage and empty
// stages fill while the output waits, so a stall drops and repeats nothing. Calibration
// words C1..C6 sit at byte addresses 0x00..0x14, 16 bits each, reset to 0; write them
// only while no item is in flight. Writes above 0x17 are ignored.
`default_nettype none

module pressure_sensor_compensation (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  psc_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output psc_pkg::out_item_t             out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [psc_pkg::CfgAddrW-1:0]   paddr,
  input  logic [psc_pkg::CfgDataW-1:0]   pwdata,
  output logic [psc_pkg::CfgDataW-1:0]   prdata,
  output logic                           pready
);
  import psc_pkg::*;

  cal_t      cal;
  logic      fo_valid;
  logic      fo_stall;
  fo_item_t  fo_data;
  logic      so_valid;
  logic      so_stall;
  so_item_t  so_data;

  psc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cal     (cal)
  );

  psc_first_order u_first (
    .clk      (clk),
    .rst_n    (rst_n),
    .cal      (cal),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .up_data  (in_data),
    .dn_valid (fo_valid),
    .dn_stall (fo_stall),
    .dn_data  (fo_data)
  );

  psc_second_order u_second (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (fo_valid),
    .up_stall (fo_stall),
    .up_data  (fo_data),
    .dn_valid (so_valid),
    .dn_stall (so_stall),
    .dn_data  (so_data)
  );

  psc_pressure u_pres (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (so_valid),
    .up_stall (so_stall),
    .up_data  (so_data),
    .dn_valid (out_valid),
    .dn_stall (out_stall),
    .dn_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: rtl/psc_cfg_regs.sv
// calibration word registers behind the APB-style port
`default_nettype none

module psc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [psc_pkg::CfgAddrW-1:0]   paddr,
  input  logic [psc_pkg::CfgDataW-1:0]   pwdata,
  output logic [psc_pkg::CfgDataW-1:0]   prdata,
  output logic                           pready,
  output psc_pkg::cal_t                  cal
);
  import psc_pkg::*;

  cal_t     cal_r;
  cal_t     cal_nxt;
  cfg_reg_t sel;
  logic     wr_en;

  assign sel   = cfg_reg_t'(paddr[CfgAddrW-1:2]);
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    cal_nxt = cal_r;
    if (wr_en) begin
      unique case (sel)
        REG_PRESSURE_SENSITIVITY: cal_nxt.pressure_sensitivity = pwdata[CalW-1:0];
        REG_PRESSURE_OFFSET:      cal_nxt.pressure_offset      = pwdata[CalW-1:0];
        REG_SENS_TEMP_COEFF:      cal_nxt.sens_temp_coeff      = pwdata[CalW-1:0];
        REG_OFFSET_TEMP_COEFF:    cal_nxt.offset_temp_coeff    = pwdata[CalW-1:0];
        REG_REFERENCE_TEMP:       cal_nxt.reference_temp       = pwdata[CalW-1:0];
        REG_TEMP_SENSITIVITY:     cal_nxt.temp_sensitivity     = pwdata[CalW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (sel)
      REG_PRESSURE_SENSITIVITY: prdata = CfgDataW'(cal_r.pressure_sensitivity);
      REG_PRESSURE_OFFSET:      prdata = CfgDataW'(cal_r.pressure_offset);
      REG_SENS_TEMP_COEFF:      prdata = CfgDataW'(cal_r.sens_temp_coeff);
      REG_OFFSET_TEMP_COEFF:    prdata = CfgDataW'(cal_r.offset_temp_coeff);
      REG_REFERENCE_TEMP:       prdata = CfgDataW'(cal_r.reference_temp);
      REG_TEMP_SENSITIVITY:     prdata = CfgDataW'(cal_r.temp_sensitivity);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else begin
      cal_r <= cal_nxt;
    end
  end

  assign pready = 1'b1;
  assign cal    = cal_r;

endmodule

`default_nettype wire

FILE: rtl/psc_first_order.sv
// first-order terms: dT, TEMP, OFF, SENS and the T2 correction
`default_nettype none

module psc_first_order (
  input  logic                clk,
  input  logic                rst_n,
  input  psc_pkg::cal_t       cal,
  input  logic                up_valid,
  output logic                up_stall,
  input  psc_pkg::in_item_t   up_data,
  output logic                dn_valid,
  input  logic                dn_stall,
  output psc_pkg::fo_item_t   dn_data
);
  import psc_pkg::*;

  localparam int Stages = 3;

  logic [Stages-1:0]        vld_r;
  logic [Stages-1:0]        adv;

  logic signed [DtW-1:0]    dt_nxt;
  logic signed [DtW-1:0]    dt_r;
  logic [RawW-1:0]          d1_s0_r;
  logic [RawW-1:0]          d1_s1_r;

  logic signed [PrW-1:0]    p6_nxt;
  logic signed [PrW-1:0]    p4_nxt;
  logic signed [PrW-1:0]    p3_nxt;
  logic signed [2*DtW-1:0]  sq;
  logic signed [PrW-1:0]    p6_r;
  logic signed [PrW-1:0]    p4_r;
  logic signed [PrW-1:0]    p3_r;
  logic [DsqW-1:0]          dsq_r;

  logic signed [TdW-1:0]    td;
  logic [T2W-2:0]           dsq_top;
  logic [T2W-1:0]           t2_cold;
  logic [DsqW+2:0]          dsq7;
  fo_item_t                 fo_nxt;
  fo_item_t                 fo_r;

  // stage advance, bubbles collapse
  always_comb begin
    adv[Stages-1] = !vld_r[Stages-1] || !dn_stall;
    for (int k = Stages - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  always_comb begin
    dt_nxt = $signed({1'b0, up_data.raw_temperature})
           - $signed({1'b0, cal.reference_temp, 8'h00});
  end

  always_comb begin
    p6_nxt = dt_r * $signed({1'b0, cal.temp_sensitivity});
    p4_nxt = dt_r * $signed({1'b0, cal.offset_temp_coeff});
    p3_nxt = dt_r * $signed({1'b0, cal.sens_temp_coeff});
    sq     = dt_r * dt_r;
  end

  always_comb begin
    td      = p6_r[TdW+22:23];
    dsq_top = dsq_r[DsqW-1:33];
    t2_cold = {1'b0, dsq_top} + {dsq_top, 1'b0};
    dsq7    = {dsq_r, 3'b000} - {3'b000, dsq_r};

    fo_nxt.td    = td;
    fo_nxt.tv    = $signed({td[TdW-1], td}) + TvW'(ColdOffset);
    fo_nxt.t2    = td[TdW-1] ? t2_cold : {2'b00, dsq7[DsqW+2:37]};
    fo_nxt.off1  = $signed({4'h0, cal.pressure_offset, 16'h0000})
                 + $signed({{2{p4_r[PrW-2]}}, p4_r[PrW-2:7]});
    fo_nxt.sens1 = $signed({4'h0, cal.pressure_sensitivity, 15'h0000})
                 + $signed({{2{p3_r[PrW-2]}}, p3_r[PrW-2:8]});
    fo_nxt.d1    = d1_s1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= up_valid;
      if (adv[1]) vld_r[1] <= vld_r[0];
      if (adv[2]) vld_r[2] <= vld_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      dt_r    <= dt_nxt;
      d1_s0_r <= up_data.raw_pressure;
    end
    if (adv[1]) begin
      p6_r    <= p6_nxt;
      p4_r    <= p4_nxt;
      p3_r    <= p3_nxt;
      dsq_r   <= sq[DsqW-1:0];
      d1_s1_r <= d1_s0_r;
    end
    if (adv[2]) begin
      fo_r <= fo_nxt;
    end
  end

  assign up_stall = !adv[0];
  assign dn_valid = vld_r[Stages-1];
  assign dn_data  = fo_r;

endmodule

`default_nettype wire

FILE: rtl/psc_second_order.sv
// second-order band corrections and final OFF, SENS and temperature
`default_nettype none

module psc_second_order (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_stall,
  input  psc_pkg::fo_item_t   up_data,
  output logic                dn_valid,
  input  logic                dn_stall,
  output psc_pkg::so_item_t   dn_data
);
  import psc_pkg::*;

  localparam int Stages = 3;

  logic [Stages-1:0]         vld_r;
  logic [Stages-1:0]         adv;

  logic signed [2*TdW-1:0]   sq_lo;
  logic signed [2*TvW-1:0]   sq_v;
  logic signed [OutW-1:0]    tout_nxt;
  logic [SqW-1:0]            lo_r;
  logic [SqW-1:0]            vlo_r;
  logic                      neg_r;
  logic                      vneg_r;
  logic signed [OutW-1:0]    tout_s0_r;
  logic signed [OutW-1:0]    tout_s1_r;
  logic signed [Off1W-1:0]   off1_s0_r;
  logic signed [Off1W-1:0]   off1_s1_r;
  logic signed [Sens1W-1:0]  sens1_s0_r;
  logic signed [Sens1W-1:0]  sens1_s1_r;
  logic [RawW-1:0]           d1_s0_r;
  logic [RawW-1:0]           d1_s1_r;

  logic [SqW+1:0]            lo3;
  logic [SqW+2:0]            lo5;
  logic [SqW+2:0]            v7;
  logic [Off2W-1:0]          off2_nxt;
  logic [Sens2W-1:0]         sens2_nxt;
  logic [Off2W-1:0]          off2_r;
  logic [Sens2W-1:0]         sens2_r;
  so_item_t                  so_nxt;
  so_item_t                  so_r;

  always_comb begin
    adv[Stages-1] = !vld_r[Stages-1] || !dn_stall;
    for (int k = Stages - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  always_comb begin
    sq_lo    = up_data.td * up_data.td;
    sq_v     = up_data.tv * up_data.tv;
    tout_nxt = $signed({{(OutW-TdW){up_data.td[TdW-1]}}, up_data.td})
             + OutW'(TempRef)
             - $signed({{(OutW-T2W){1'b0}}, up_data.t2});
  end

  // cold band below 20.00 C, extra term below -15.00 C
  always_comb begin
    lo3 = {2'b00, lo_r} + {1'b0, lo_r, 1'b0};
    lo5 = {1'b0, lo_r, 2'b00} + {3'b000, lo_r};
    v7  = {vlo_r, 3'b000} - {3'b000, vlo_r};
    if (neg_r) begin
      off2_nxt  = {{(Off2W-SqW-1){1'b0}}, lo3[SqW+1:1]}
                + (vneg_r ? {{(Off2W-SqW-3){1'b0}}, v7} : '0);
      sens2_nxt = {{(Sens2W-SqW){1'b0}}, lo5[SqW+2:3]}
                + (vneg_r ? {{(Sens2W-SqW-2){1'b0}}, vlo_r, 2'b00} : '0);
    end else begin
      off2_nxt  = {{(Off2W-SqW+4){1'b0}}, lo_r[SqW-1:4]};
      sens2_nxt = '0;
    end
  end

  always_comb begin
    so_nxt.tout = tout_s1_r;
    so_nxt.off  = $signed({{(OffW-Off1W){off1_s1_r[Off1W-1]}}, off1_s1_r})
                - $signed({{(OffW-Off2W){1'b0}}, off2_r});
    so_nxt.sens = $signed({{(SensW-Sens1W){sens1_s1_r[Sens1W-1]}}, sens1_s1_r})
                - $signed({{(SensW-Sens2W){1'b0}}, sens2_r});
    so_nxt.d1   = d1_s1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= up_valid;
      if (adv[1]) vld_r[1] <= vld_r[0];
      if (adv[2]) vld_r[2] <= vld_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      lo_r       <= sq_lo[SqW-1:0];
      vlo_r      <= sq_v[SqW-1:0];
      neg_r      <= up_data.td[TdW-1];
      vneg_r     <= up_data.tv[TvW-1];
      tout_s0_r  <= tout_nxt;
      off1_s0_r  <= up_data.off1;
      sens1_s0_r <= up_data.sens1;
      d1_s0_r    <= up_data.d1;
    end
    if (adv[1]) begin
      off2_r     <= off2_nxt;
      sens2_r    <= sens2_nxt;
      tout_s1_r  <= tout_s0_r;
      off1_s1_r  <= off1_s0_r;
      sens1_s1_r <= sens1_s0_r;
      d1_s1_r    <= d1_s0_r;
    end
    if (adv[2]) begin
      so_r <= so_nxt;
    end
  end

  assign up_stall = !adv[0];
  assign dn_valid = vld_r[Stages-1];
  assign dn_data  = so_r;

endmodule

`default_nettype wire

FILE: rtl/psc_pressure.sv
// pressure: split SENS x D1 product, two truncating scalings, output register
`default_nettype none

module psc_pressure (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_stall,
  input  psc_pkg::so_item_t   up_data,
  output logic                dn_valid,
  input  logic                dn_stall,
  output psc_pkg::out_item_t  dn_data
);
  import psc_pkg::*;

  localparam int Stages = 5;

  logic [Stages-1:0]        vld_r;
  logic [Stages-1:0]        adv;

  logic [PpW-1:0]           pl_nxt;
  logic signed [PpW-1:0]    ph_nxt;
  logic [PpW-1:0]           pl_r;
  logic signed [PpW-1:0]    ph_r;
  logic signed [ProdW:0]    wide;
  logic signed [ProdW-1:0]  prod_r;
  logic signed [ProdW-1:0]  bq;
  logic signed [QW-1:0]     q_r;
  logic signed [XW-1:0]     x_nxt;
  logic signed [XW-1:0]     x_r;
  logic signed [XW-1:0]     bx;
  out_item_t                out_nxt;
  out_item_t                out_r;

  logic signed [OffW-1:0]   off_s0_r;
  logic signed [OffW-1:0]   off_s1_r;
  logic signed [OffW-1:0]   off_s2_r;
  logic signed [OutW-1:0]   tout_s0_r;
  logic signed [OutW-1:0]   tout_s1_r;
  logic signed [OutW-1:0]   tout_s2_r;
  logic signed [OutW-1:0]   tout_s3_r;

  always_comb begin
    adv[Stages-1] = !vld_r[Stages-1] || !dn_stall;
    for (int k = Stages - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  always_comb begin
    pl_nxt = up_data.sens[SplitW-1:0] * up_data.d1;
    ph_nxt = $signed(up_data.sens[SensW-1:SplitW]) * $signed({1'b0, up_data.d1});
    wide   = $signed({ph_r, {SplitW{1'b0}}}) + $signed({{SplitW{1'b0}}, pl_r});
  end

  // truncate toward zero: bias negatives before the shift
  always_comb begin
    bq    = prod_r + (prod_r[ProdW-1] ? ProdW'((64'd1 << ProdShift) - 64'd1) : '0);
    x_nxt = $signed({q_r[QW-1], q_r})
          - $signed({{(XW-OffW){off_s2_r[OffW-1]}}, off_s2_r});
    bx    = x_r + (x_r[XW-1] ? XW'((64'd1 << PresShift) - 64'd1) : '0);
    out_nxt.temperature_centi   = tout_s3_r;
    out_nxt.pressure_tenth_mbar = $signed({{(OutW-PW){bx[XW-1]}}, bx[XW-1:PresShift]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= up_valid;
      if (adv[1]) vld_r[1] <= vld_r[0];
      if (adv[2]) vld_r[2] <= vld_r[1];
      if (adv[3]) vld_r[3] <= vld_r[2];
      if (adv[4]) vld_r[4] <= vld_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pl_r      <= pl_nxt;
      ph_r      <= ph_nxt;
      off_s0_r  <= up_data.off;
      tout_s0_r <= up_data.tout;
    end
    if (adv[1]) begin
      prod_r    <= wide[ProdW-1:0];
      off_s1_r  <= off_s0_r;
      tout_s1_r <= tout_s0_r;
    end
    if (adv[2]) begin
      q_r       <= bq[ProdW-1:ProdShift];
      off_s2_r  <= off_s1_r;
      tout_s2_r <= tout_s1_r;
    end
    if (adv[3]) begin
      x_r       <= x_nxt;
      tout_s3_r <= tout_s2_r;
    end
    if (adv[4]) begin
      out_r <= out_nxt;
    end
  end

  assign up_stall = !adv[0];
  assign dn_valid = vld_r[Stages-1];
  assign dn_data  = out_r;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// self-checking testbench for the pressure sensor compensation block

class compensation_checker;
  localparam longint ProdScale = 64'sd2097152;
  localparam longint PresScale = 64'sd32768;

  psc_pkg::cal_t     cal;
  psc_pkg::out_item_t expected_readings[$];
  int unsigned       mismatches;

  function new();
    cal = '0;
    mismatches = 0;
  endfunction

  function void set_word(logic [2:0] idx, logic [31:0] value);
    case (idx)
      psc_pkg::REG_PRESSURE_SENSITIVITY: cal.pressure_sensitivity = value[15:0];
      psc_pkg::REG_PRESSURE_OFFSET:      cal.pressure_offset = value[15:0];
      psc_pkg::REG_SENS_TEMP_COEFF:      cal.sens_temp_coeff = value[15:0];
      psc_pkg::REG_OFFSET_TEMP_COEFF:    cal.offset_temp_coeff = value[15:0];
      psc_pkg::REG_REFERENCE_TEMP:       cal.reference_temp = value[15:0];
      psc_pkg::REG_TEMP_SENSITIVITY:     cal.temp_sensitivity = value[15:0];
      default: ;
    endcase
  endfunction

  function psc_pkg::out_item_t compensate(psc_pkg::in_item_t r);
    longint d1, dt, temp, dsq, sq, cold, t2, off2, sens2, off, sens, p, tout;
    psc_pkg::out_item_t res;
    d1   = longint'(r.raw_pressure);
    dt   = longint'(r.raw_temperature) - (longint'(cal.reference_temp) << 8);
    temp = ((dt * longint'(cal.temp_sensitivity)) >>> 23) + psc_pkg::TempRef;
    dsq  = dt * dt;
    sq   = (temp - psc_pkg::TempRef) * (temp - psc_pkg::TempRef);
    if (temp < psc_pkg::TempRef) begin
      t2    = 3 * (dsq >>> 33);
      off2  = 3 * sq / 2;
      sens2 = 5 * sq / 8;
      if (temp < psc_pkg::TempCold) begin
        cold  = (temp - psc_pkg::TempCold) * (temp - psc_pkg::TempCold);
        off2  = off2 + 7 * cold;
        sens2 = sens2 + 4 * cold;
      end
    end else begin
      t2    = (7 * dsq) >>> 37;
      off2  = sq / 16;
      sens2 = 0;
    end
    off  = (longint'(cal.pressure_offset) << 16)
         + ((longint'(cal.offset_temp_coeff) * dt) >>> 7) - off2;
    sens = (longint'(cal.pressure_sensitivity) << 15)
         + ((longint'(cal.sens_temp_coeff) * dt) >>> 8) - sens2;
    p    = ((sens * d1) / ProdScale - off) / PresScale;
    tout = temp - t2;
    res.temperature_centi   = tout[31:0];
    res.pressure_tenth_mbar = p[31:0];
    return res;
  endfunction

  function int pending();
    return expected_readings.size();
  endfunction

  function void note_reading(psc_pkg::in_item_t r);
    expected_readings.push_back(compensate(r));
  endfunction

  task report(string what);
    $display("mismatch: %s", what);
    mismatches++;
  endtask

  task check_reading(psc_pkg::out_item_t got);
    psc_pkg::out_item_t want;
    if (expected_readings.size() == 0) begin
      report($sformatf("unexpected item temperature %0d pressure %0d",
                       got.temperature_centi, got.pressure_tenth_mbar));
      return;
    end
    want = expected_readings.pop_front();
    if (got.temperature_centi !== want.temperature_centi)
      report($sformatf("temperature_centi got %0d want %0d",
                       got.temperature_centi, want.temperature_centi));
    if (got.pressure_tenth_mbar !== want.pressure_tenth_mbar)
      report($sformatf("pressure_tenth_mbar got %0d want %0d",
                       got.pressure_tenth_mbar, want.pressure_tenth_mbar));
  endtask
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import psc_pkg::*;

  localparam int ResetCycles = 10;
  localparam int PipeLatency = 11;
  localparam int IdleLimit = 2000;
  localparam int NumRegs = 6;
  localparam logic [2:0] RegUnmappedLo = 3'd6;
  localparam logic [2:0] RegUnmappedHi = 3'd7;
  localparam int RandomPhases = 8;
  localparam int ItemsPerPhase = 92;
  localparam logic [RawW-1:0] RawMax = '1;
  localparam logic [RawW-1:0] BoundCenter = 24'h800000;
  localparam logic [CalW-1:0] CalMax = '1;
  localparam logic [CalW-1:0] BoundWord = 16'h8000;
  localparam logic [CalW-1:0] TypC1 = 16'd46372;
  localparam logic [CalW-1:0] TypC2 = 16'd43981;
  localparam logic [CalW-1:0] TypC3 = 16'd29059;
  localparam logic [CalW-1:0] TypC4 = 16'd27842;
  localparam logic [CalW-1:0] TypC5 = 16'd31553;
  localparam logic [CalW-1:0] TypC6 = 16'd28165;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [CfgDataW-1:0] pwdata = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;
  int                  idle_cycles = 0;
  bit                  in_calm = 1'b0;
  compensation_checker comp_model;

  pressure_sensor_compensation dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int gap_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] noisy(logic [CalW-1:0] word);
    logic [31:0] v;
    v = $urandom();
    v[CalW-1:0] = word;
    return v;
  endfunction

  function automatic logic [CalW-1:0] pick_cal_word();
    int unsigned roll;
    logic [CalW-1:0] w;
    roll = $urandom_range(0, 9);
    if (roll < 2) return '0;
    if (roll < 4) return CalMax;
    w = CalW'($urandom());
    return w;
  endfunction

  function automatic logic [RawW-1:0] pick_raw_temp();
    longint center, reach, v;
    int unsigned roll;
    center = longint'(comp_model.cal.reference_temp) << 8;
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      reach = longint'(1) << $urandom_range(2, 22);
      v = center + longint'($urandom_range(0, 32'(2 * reach))) - reach;
    end else if (roll < 60) begin
      case ($urandom_range(0, 3))
        0: v = 0;
        1: v = RawMax;
        2: v = center - 1;
        default: v = center + 1;
      endcase
    end else begin
      v = longint'($urandom_range(0, RawMax));
    end
    if (v < 0) v = 0;
    if (v > RawMax) v = RawMax;
    return v[RawW-1:0];
  endfunction

  function automatic logic [RawW-1:0] pick_raw_pressure();
    int unsigned roll;
    logic [RawW-1:0] v;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return RawMax;
    v = RawW'($urandom());
    return v;
  endfunction

  task automatic send_pair(input logic [RawW-1:0] d2, input logic [RawW-1:0] d1);
    in_item_t r;
    int n;
    r.raw_temperature = d2;
    r.raw_pressure = d1;
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall !== 1'b0);
    comp_model.note_reading(r);
    @(negedge clk);
    n = gap_len();
    if (!in_calm && n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (comp_model.pending() != 0) @(negedge clk);
    repeat (PipeLatency) @(negedge clk);
  endtask

  task automatic program_word(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    comp_model.set_word(idx, value);
    @(negedge clk);
  endtask

  task automatic bus_idle();
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin : out_side
    int hold;
    bit calm;
    hold = 0;
    calm = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) == 0) calm = !calm;
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
        if (!calm) hold = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) comp_model.check_reading(out_data);
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IdleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    comp_model = new();
    repeat (ResetCycles) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // calibration at reset values
    send_pair('0, '0);
    send_pair(RawMax, RawMax);
    settle();

    program_word(REG_PRESSURE_SENSITIVITY, noisy(TypC1));
    program_word(REG_PRESSURE_OFFSET, noisy(TypC2));
    program_word(REG_SENS_TEMP_COEFF, noisy(TypC3));
    program_word(REG_OFFSET_TEMP_COEFF, noisy(TypC4));
    program_word(REG_REFERENCE_TEMP, noisy(TypC5));
    program_word(REG_TEMP_SENSITIVITY, noisy(TypC6));
    program_word(RegUnmappedLo, $urandom());
    program_word(RegUnmappedHi, $urandom());
    bus_idle();
    send_pair(24'd8569150, 24'd4311550);
    send_pair('0, '0);
    send_pair(RawMax, RawMax);
    send_pair({TypC5, 8'h00}, 24'h800000);
    send_pair('0, RawMax);
    settle();

    // band edges: temperature rises by one count per 256 counts of dT
    program_word(REG_REFERENCE_TEMP, noisy(BoundWord));
    program_word(REG_TEMP_SENSITIVITY, noisy(BoundWord));
    bus_idle();
    send_pair(BoundCenter - 24'd896001, RawMax);
    send_pair(BoundCenter - 24'd896000, 24'h000000);
    send_pair(BoundCenter - 24'd895744, 24'hA5A5A5);
    send_pair(BoundCenter - 24'd256, 24'h5A5A5A);
    send_pair(BoundCenter - 24'd1, RawMax);
    send_pair(BoundCenter, 24'h123456);
    send_pair(BoundCenter + 24'd255, 24'hFEDCBA);
    settle();

    program_word(REG_PRESSURE_SENSITIVITY, '1);
    program_word(REG_PRESSURE_OFFSET, '1);
    program_word(REG_SENS_TEMP_COEFF, '1);
    program_word(REG_OFFSET_TEMP_COEFF, '1);
    program_word(REG_REFERENCE_TEMP, '1);
    program_word(REG_TEMP_SENSITIVITY, '1);
    bus_idle();
    send_pair('0, RawMax);
    send_pair(RawMax, RawMax);
    send_pair('0, '0);
    send_pair({CalMax, 8'h00}, 24'h555555);

    for (int p = 0; p < RandomPhases; p++) begin
      settle();
      for (int i = 0; i < NumRegs; i++) program_word(i[2:0], noisy(pick_cal_word()));
      bus_idle();
      for (int k = 0; k < ItemsPerPhase; k++) begin
        if (k == ItemsPerPhase / 2) settle();
        if ($urandom_range(0, 63) == 0) in_calm = !in_calm;
        send_pair(pick_raw_temp(), pick_raw_pressure());
      end
    end
    settle();

    if (comp_model.mismatches == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end
endmodule

FILE: pressure_sensor_compensation.f
rtl/psc_pkg.sv
rtl/psc_cfg_regs.sv
rtl/psc_first_order.sv
rtl/psc_second_order.sv
rtl/psc_pressure.sv
rtl/pressure_sensor_compensation.sv
tb/testbench.sv
